// ===== src/abbc_pkg.sv =====
// Shared types and constants for the alpha bounding-box clip block.
// Used by the front tracker, the box queue, the output stage and the top level.
`default_nettype none

package abbc_pkg;

    // Field widths fixed by the stream format
    localparam int COORD_W        = 12;
    localparam int DIM_W          = 13;
    localparam int ALPHA_W        = 8;
    localparam int COORD_ALL_ONES = 4095;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_KEY_ALPHA    = 2'd2,
        REG_HAS_ALPHA    = 2'd3
    } reg_index_t;

    // Register reset values
    localparam logic [DIM_W-1:0]   FRAME_WIDTH_RST  = 13'd64;
    localparam logic [DIM_W-1:0]   FRAME_HEIGHT_RST = 13'd64;
    localparam logic [ALPHA_W-1:0] KEY_ALPHA_RST    = 8'd16;
    localparam logic               HAS_ALPHA_RST    = 1'b1;

    // Box queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QLVL_W = 2;

    // Stream packing
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 80;
    localparam int M_PAD_W   = M_TDATA_W - 4 * COORD_W - 2 * DIM_W;

    typedef struct packed {
        logic [DIM_W-1:0]   frame_width;
        logic [DIM_W-1:0]   frame_height;
        logic [ALPHA_W-1:0] key_alpha;
        logic               has_alpha;
    } cfg_t;

    // One finished frame: inclusive corners before masking
    typedef struct packed {
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] bottom;
        logic             all_empty;
    } box_rec_t;

    // Position of the next pixel in the frame
    typedef struct packed {
        logic [DIM_W-1:0] column;
        logic [DIM_W-1:0] row;
    } pos_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QLVL_W-1:0] level;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== src/alpha_bounding_box_clip.sv =====
// Alpha bounding-box clip (auto-crop): top level with configuration registers.
// Instantiates abbc_front, abbc_queue and abbc_back; depends on abbc_pkg.
//
// The block takes one alpha byte per clock in raster order and, on the last
// pixel of each frame, emits one beat with the tightest box around every pixel
// whose alpha differs from key_alpha, or the whole frame with all_empty set.
// Pixels are accepted at one per cycle while the box queue is not full; the
// front tracker does a compare and a min/max update per pixel. The result
// leaves through a two-entry box queue and the output register, so the input
// stalls only when two boxes wait behind a stalled output. Frame sizes
// of 0 act as 1 and sizes above MAX_DIM act as MAX_DIM. Write configuration
// only while no frame is in progress; cfg_ready is always high.
`default_nettype none

module alpha_bounding_box_clip #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [abbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [abbc_pkg::CFG_DATA_W-1:0]    cfg_data,
    // pixel stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [abbc_pkg::S_TDATA_W-1:0]     s_tdata,  // [7:0] pixel_alpha
    // box stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [11:0] box_left, [23:12] box_top, [35:24] box_right, [47:36] box_bottom,
    // [60:48] box_width, [73:61] box_height, [79:74] zero
    output logic [abbc_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic [0:0]                              m_tuser   // [0] all_empty
);
    import abbc_pkg::*;

    cfg_t          cfg_reg;
    box_rec_t      push_rec, head_rec;
    pos_t          front_pos;
    queue_status_t q_stat;
    logic          q_push, q_pop;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width  <= FRAME_WIDTH_RST;
            cfg_reg.frame_height <= FRAME_HEIGHT_RST;
            cfg_reg.key_alpha    <= KEY_ALPHA_RST;
            cfg_reg.has_alpha    <= HAS_ALPHA_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (reg_index_t'(cfg_index))
                REG_FRAME_WIDTH:  cfg_reg.frame_width  <= cfg_data;
                REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data;
                REG_KEY_ALPHA:    cfg_reg.key_alpha    <= cfg_data[ALPHA_W-1:0];
                REG_HAS_ALPHA:    cfg_reg.has_alpha    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    abbc_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .in_valid (s_tvalid),
        .in_alpha (s_tdata[ALPHA_W-1:0]),
        .in_ready (s_tready),
        .q_full   (q_stat.full),
        .push     (q_push),
        .rec      (push_rec),
        .pos      (front_pos)
    );

    abbc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_rec (push_rec),
        .pop      (q_pop),
        .head     (head_rec),
        .status   (q_stat)
    );

    abbc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head_rec),
        .q_empty  (q_stat.empty),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Frame end restarts the raster position
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |=> (front_pos.column == '0 && front_pos.row == '0))
        else $error("position not cleared after frame end");

    // Queue level stays within its depth
    a_queue_level: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.level <= QLVL_W'(QDEPTH))
        else $error("box queue overflow");

    // An empty frame reports its box from the origin
    a_empty_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[11:0] == '0 && m_tdata[23:12] == '0))
        else $error("empty frame box does not start at origin");

endmodule

`default_nettype wire

// ===== src/abbc_front.sv =====
// Front tracker: accepts alpha beats, keeps the raster position and the
// bounding box of pixels whose alpha differs from the key, and pushes one box record per frame.
// Depends on abbc_pkg.
`default_nettype none

module abbc_front #(
    parameter int MAX_DIM = 4096
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire abbc_pkg::cfg_t                    cfg,
    input  wire logic                              in_valid,
    input  wire logic [abbc_pkg::ALPHA_W-1:0]      in_alpha,
    output logic                                   in_ready,
    input  wire logic                              q_full,
    output logic                                   push,
    output abbc_pkg::box_rec_t                     rec,
    output abbc_pkg::pos_t                         pos
);
    import abbc_pkg::*;

    // Dimensions never exceed what a 13-bit register can hold
    localparam int LIM   = (MAX_DIM < 8191) ? MAX_DIM : 8191;
    localparam int CNT_W = $clog2(LIM);
    localparam logic [CNT_W-1:0] MIN_INIT =
        (CNT_W >= COORD_W) ? CNT_W'(COORD_ALL_ONES) : {CNT_W{1'b1}};
    localparam logic [DIM_W-1:0] W_LIM = DIM_W'(LIM);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] min_col_reg, min_col_next;
    logic [CNT_W-1:0] max_col_reg, max_col_next;
    logic [CNT_W-1:0] min_row_reg, min_row_next;
    logic [CNT_W-1:0] max_row_reg, max_row_next;
    logic             seen_reg, seen_next;

    logic [DIM_W-1:0]   w_eff, h_eff, w_last, h_last;
    logic [ALPHA_W-1:0] alpha_eff;
    logic               accept, differs, last_col, last_row, frame_end;

    // Clamp dimensions and classify the pixel
    always_comb begin
        if (cfg.frame_width == '0) begin
            w_eff = DIM_W'(1);
        end else if (cfg.frame_width > W_LIM) begin
            w_eff = W_LIM;
        end else begin
            w_eff = cfg.frame_width;
        end
        if (cfg.frame_height == '0) begin
            h_eff = DIM_W'(1);
        end else if (cfg.frame_height > W_LIM) begin
            h_eff = W_LIM;
        end else begin
            h_eff = cfg.frame_height;
        end
        w_last    = w_eff - DIM_W'(1);
        h_last    = h_eff - DIM_W'(1);
        alpha_eff = cfg.has_alpha ? in_alpha : '0;
        differs   = (alpha_eff != cfg.key_alpha);
        last_col  = (DIM_W'(col_reg) >= w_last);
        last_row  = (DIM_W'(row_reg) >= h_last);
    end

    assign in_ready  = !q_full;
    assign accept    = in_valid && in_ready;
    assign frame_end = last_col && last_row;
    assign push      = accept && frame_end;

    // Update trackers with the current pixel
    always_comb begin
        min_col_next = min_col_reg;
        max_col_next = max_col_reg;
        min_row_next = min_row_reg;
        max_row_next = max_row_reg;
        seen_next    = seen_reg;
        if (differs) begin
            if (col_reg < min_col_reg) begin
                min_col_next = col_reg;
            end
            if (col_reg > max_col_reg) begin
                max_col_next = col_reg;
            end
            if (row_reg < min_row_reg) begin
                min_row_next = row_reg;
            end
            if (row_reg > max_row_reg) begin
                max_row_next = row_reg;
            end
            seen_next = 1'b1;
        end
        if (last_col) begin
            col_next = '0;
            row_next = row_reg + CNT_W'(1);
        end else begin
            col_next = col_reg + CNT_W'(1);
            row_next = row_reg;
        end
    end

    // Build the box record from the updated trackers, or the whole frame if no pixel differed
    always_comb begin
        if (seen_next) begin
            rec.left      = DIM_W'(min_col_next);
            rec.top       = DIM_W'(min_row_next);
            rec.right     = DIM_W'(max_col_next);
            rec.bottom    = DIM_W'(max_row_next);
            rec.all_empty = 1'b0;
        end else begin
            rec.left      = '0;
            rec.top       = '0;
            rec.right     = w_last;
            rec.bottom    = h_last;
            rec.all_empty = 1'b1;
        end
    end

    // Advance position and trackers; clear them at frame end
    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            col_reg     <= '0;
            row_reg     <= '0;
            min_col_reg <= MIN_INIT;
            max_col_reg <= '0;
            min_row_reg <= MIN_INIT;
            max_row_reg <= '0;
            seen_reg    <= 1'b0;
        end else if (accept) begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            min_col_reg <= min_col_next;
            max_col_reg <= max_col_next;
            min_row_reg <= min_row_next;
            max_row_reg <= max_row_next;
            seen_reg    <= seen_next;
        end
    end

    assign pos.column = DIM_W'(col_reg);
    assign pos.row    = DIM_W'(row_reg);

endmodule

`default_nettype wire

// ===== src/abbc_queue.sv =====
// Two-entry queue of finished box records between the front tracker and
// the output stage. Depends on abbc_pkg.
`default_nettype none

module abbc_queue (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      push,
    input  wire abbc_pkg::box_rec_t        push_rec,
    input  wire logic                      pop,
    output abbc_pkg::box_rec_t             head,
    output abbc_pkg::queue_status_t        status
);
    import abbc_pkg::*;

    box_rec_t          entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QLVL_W-1:0] level_reg, level_next;

    assign status.full  = (level_reg == QLVL_W'(QDEPTH));
    assign status.empty = (level_reg == '0);
    assign status.level = level_reg;
    assign head         = entry_reg[rd_ptr_reg];

    // Track fill level
    always_comb begin
        level_next = level_reg;
        if (push && !pop) begin
            level_next = level_reg + QLVL_W'(1);
        end else if (pop && !push) begin
            level_next = level_reg - QLVL_W'(1);
        end
    end

    // Advance pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            level_reg <= level_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

// ===== src/abbc_back.sv =====
// Output stage: pops box records, works out width and height, masks the
// corners to 12 bits and holds the result beat until taken. Depends on abbc_pkg.
`default_nettype none

module abbc_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire abbc_pkg::box_rec_t                head,
    input  wire logic                              q_empty,
    output logic                                   pop,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [abbc_pkg::M_TDATA_W-1:0]         m_tdata,
    output logic [0:0]                             m_tuser
);
    import abbc_pkg::*;

    logic                 valid_reg;
    logic [M_TDATA_W-1:0] data_reg, data_next;
    logic                 empty_flag_reg;
    logic [DIM_W-1:0]     box_w, box_h;

    assign pop = !q_empty && (!valid_reg || m_tready);

    // Size and pack the head record
    always_comb begin
        box_w     = head.right - head.left + DIM_W'(1);
        box_h     = head.bottom - head.top + DIM_W'(1);
        data_next = {{M_PAD_W{1'b0}}, box_h, box_w,
                     head.bottom[COORD_W-1:0], head.right[COORD_W-1:0],
                     head.top[COORD_W-1:0], head.left[COORD_W-1:0]};
    end

    // Hold the beat until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg       <= data_next;
            empty_flag_reg <= head.all_empty;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = data_reg;
    assign m_tuser[0] = empty_flag_reg;

endmodule

`default_nettype wire

// ===== dv/alpha_bounding_box_clip_tb.sv =====
// Self-checking testbench for alpha_bounding_box_clip: raster pixel beats in, clip boxes out.
// Depends on abbc_pkg and the alpha_bounding_box_clip RTL; predicts each box from its own
// frame tracker and checks every result beat field by field.
`default_nettype none

module alpha_bounding_box_clip_tb;
    import abbc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIM = 4096;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic               all_empty;
    } clip_box_t;

    typedef enum int {
        FRAME_EMPTY,
        FRAME_SPARSE,
        FRAME_NOISE,
        FRAME_DOT,
        FRAME_CORNER
    } frame_style_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;   // [7:0] pixel_alpha
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // [11:0] left, [23:12] top, [35:24] right, [47:36] bottom,
    // [60:48] width, [73:61] height, [79:74] zero
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [0:0]            m_tuser;          // [0] all_empty

    // Pixels waiting to be sent and boxes waiting to come back
    logic [ALPHA_W-1:0] pending_pixels[$];
    clip_box_t          expected_boxes[$];

    int unsigned error_count   = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    bit          pixel_taken   = 1'b0;

    // Register copies and frame tracker state
    logic [DIM_W-1:0]   set_width;
    logic [DIM_W-1:0]   set_height;
    logic [ALPHA_W-1:0] set_key;
    logic               set_has_alpha;
    int unsigned        scan_col, scan_row;
    int unsigned        hit_min_col, hit_max_col, hit_min_row, hit_max_row;
    bit                 hit_any;

    alpha_bounding_box_clip #(
        .MAX_DIM (MAX_DIM)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #2 aclk = ~aclk;

    task automatic report_error(string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want) begin
            report_error($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    // Sizes of 0 act as 1, sizes above MAX_DIM act as MAX_DIM
    function automatic int unsigned dim_in_effect(logic [DIM_W-1:0] raw);
        if (raw == 0) begin
            return 1;
        end
        if (raw > MAX_DIM) begin
            return MAX_DIM;
        end
        return raw;
    endfunction

    function automatic void clear_scan();
        scan_col    = 0;
        scan_row    = 0;
        hit_min_col = COORD_ALL_ONES;
        hit_max_col = 0;
        hit_min_row = COORD_ALL_ONES;
        hit_max_row = 0;
        hit_any     = 1'b0;
    endfunction

    // Advance the tracker by one pixel; queue a box on the last pixel of the frame
    function automatic void track_pixel(logic [ALPHA_W-1:0] alpha);
        int unsigned w, h, a, l, t, r, b;
        bit          last_col, last_row;
        clip_box_t   box;
        w = dim_in_effect(set_width);
        h = dim_in_effect(set_height);
        a = set_has_alpha ? alpha : 0;
        last_col = scan_col >= w - 1;
        last_row = scan_row >= h - 1;
        if (a != set_key) begin
            if (scan_col < hit_min_col) hit_min_col = scan_col;
            if (scan_col > hit_max_col) hit_max_col = scan_col;
            if (scan_row < hit_min_row) hit_min_row = scan_row;
            if (scan_row > hit_max_row) hit_max_row = scan_row;
            hit_any = 1'b1;
        end
        if (last_col && last_row) begin
            if (hit_any) begin
                l = hit_min_col;
                t = hit_min_row;
                r = hit_max_col;
                b = hit_max_row;
            end else begin
                l = 0;
                t = 0;
                r = w - 1;
                b = h - 1;
            end
            box.left      = COORD_W'(l);
            box.top       = COORD_W'(t);
            box.right     = COORD_W'(r);
            box.bottom    = COORD_W'(b);
            box.width     = DIM_W'(r - l + 1);
            box.height    = DIM_W'(b - t + 1);
            box.all_empty = !hit_any;
            expected_boxes.push_back(box);
            clear_scan();
        end else if (last_col) begin
            scan_col = 0;
            scan_row++;
        end else begin
            scan_col++;
        end
    endfunction

    // Driver: predict on each accepted pixel beat
    always @(posedge aclk) begin
        pixel_taken = aresetn && s_tvalid && s_tready;
        if (pixel_taken) begin
            track_pixel(s_tdata);
            void'(pending_pixels.pop_front());
        end
    end

    // Driver: hold an unaccepted beat, else offer the next pixel or idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || pixel_taken) begin
            if (pending_pixels.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_pixels[0];
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each box beat with the oldest prediction
    always @(posedge aclk) begin : box_check
        clip_box_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_boxes.size() == 0) begin
                report_error($sformatf("box beat with none expected, tdata=%h", m_tdata));
            end else begin
                want = expected_boxes.pop_front();
                check_field("box_left",   m_tdata[11:0],  want.left);
                check_field("box_top",    m_tdata[23:12], want.top);
                check_field("box_right",  m_tdata[35:24], want.right);
                check_field("box_bottom", m_tdata[47:36], want.bottom);
                check_field("box_width",  m_tdata[60:48], want.width);
                check_field("box_height", m_tdata[73:61], want.height);
                check_field("tdata pad",  m_tdata[79:74], 0);
                check_field("all_empty",  m_tuser[0],     want.all_empty);
            end
        end
    end

    // Monitor: random backpressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= $urandom_range(0, 99) >= recv_stall_pct;
        end
    end

    function automatic void set_idle_mode(int unsigned mode);
        case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
    endfunction

    // Hold until every pixel is sent and every box has come back, then let the block settle
    task automatic drain_boxes();
        while (pending_pixels.size() != 0 || s_tvalid || expected_boxes.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_FRAME_WIDTH:  set_width     = value;
            REG_FRAME_HEIGHT: set_height    = value;
            REG_KEY_ALPHA:    set_key       = value[ALPHA_W-1:0];
            REG_HAS_ALPHA:    set_has_alpha = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Write all registers once the block is idle; unused data bits get random fill
    task automatic configure(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                             logic [ALPHA_W-1:0] key, logic has);
        drain_boxes();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_KEY_ALPHA, {5'($urandom), key});
        write_reg(REG_HAS_ALPHA, {12'($urandom), has});
    endtask

    task automatic queue_pixels(logic [ALPHA_W-1:0] vals[]);
        foreach (vals[i]) begin
            pending_pixels.push_back(vals[i]);
        end
    endtask

    // Queue one whole frame at the current size; returns its pixel count
    task automatic queue_frame(frame_style_t style, output int unsigned count);
        int unsigned        n, dot;
        logic [ALPHA_W-1:0] px;
        n = dim_in_effect(set_width) * dim_in_effect(set_height);
        dot = (style == FRAME_CORNER) ? n - 1 : $urandom_range(0, n - 1);
        for (int unsigned i = 0; i < n; i++) begin
            case (style)
                FRAME_EMPTY:  px = set_key;
                FRAME_SPARSE: px = ($urandom_range(0, 9) == 0) ? 8'($urandom) : set_key;
                FRAME_NOISE:  px = 8'($urandom);
                default:      px = (i == dot) ? ~set_key : set_key;
            endcase
            pending_pixels.push_back(px);
        end
        count = n;
    endtask

    initial begin
        int unsigned        random_pixels, random_frames, phase, count, n_frames;
        logic [ALPHA_W-1:0] key;
        set_width     = FRAME_WIDTH_RST;
        set_height    = FRAME_HEIGHT_RST;
        set_key       = KEY_ALPHA_RST;
        set_has_alpha = HAS_ALPHA_RST;
        clear_scan();
        random_pixels = 0;
        random_frames = 0;
        phase         = 0;

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Reset configuration: one 64x64 frame with a single hit
        set_idle_mode(1);
        queue_frame(FRAME_DOT, count);

        // Directed frames
        set_idle_mode(0);
        configure(13'd3, 13'd2, 8'd16, 1'b1);
        queue_pixels('{16, 16, 16, 16, 16, 16});        // nothing differs: whole frame
        queue_pixels('{16, 16, 0, 16, 255, 16});        // alpha extremes: cols 1..2, rows 0..1
        configure(13'd3, 13'd2, 8'd0, 1'b0);
        queue_pixels('{255, 255, 255, 255, 255, 255});  // no alpha: all read as key 0
        configure(13'd2, 13'd2, 8'd16, 1'b0);
        queue_pixels('{16, 16, 16, 16});                // no alpha: all read 0, all differ
        configure(13'd0, 13'd0, 8'd200, 1'b1);
        queue_pixels('{200});                           // zero size acts as 1x1, empty
        queue_pixels('{0});                             // 1x1 with a hit

        // Random phases, with two phases at the largest sizes
        while (random_pixels < 1200 || random_frames < 48) begin
            set_idle_mode(phase % 4);
            if (phase == 3 || phase == 9) begin
                // widest row (oversize acts as MAX_DIM) or tallest column
                if (phase == 3) configure(13'h1FFF, 13'd0, 8'($urandom), 1'b1);
                else configure(13'd1, 13'd4096, 8'($urandom), 1'b1);
                queue_frame(FRAME_CORNER, count);
                queue_frame(FRAME_EMPTY, count);
                queue_frame(FRAME_SPARSE, count);
            end else begin
                case ($urandom_range(0, 3))
                    0: key = 8'd0;
                    1: key = 8'd255;
                    default: key = 8'($urandom);
                endcase
                configure(DIM_W'($urandom_range(0, 12)), DIM_W'($urandom_range(0, 12)),
                          key, $urandom_range(0, 9) != 0);
                n_frames = $urandom_range(1, 4);
                repeat (n_frames) begin
                    queue_frame(frame_style_t'($urandom_range(0, 4)), count);
                    random_pixels += count;
                    random_frames++;
                end
            end
            phase++;
        end

        drain_boxes();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("Timeout: %0d pixels and %0d boxes still outstanding",
                 pending_pixels.size(), expected_boxes.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
